/* src/i2cm_pkg.sv */
package i2cm_pkg;

   localparam int DELAY_CFG_W = 16;
   localparam int RETRY_W     = 3;
   localparam int SEG_W       = 5;

   // command codes
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_WRITE = 3'd2;
   localparam logic [2:0] CMD_READ  = 3'd3;
   localparam logic [2:0] CMD_STOP  = 3'd4;

   // register indexes
   localparam logic CSR_DELAY = 1'b0;
   localparam logic CSR_RETRY = 1'b1;

   localparam logic [DELAY_CFG_W-1:0] DELAY_RESET = 16'd10;
   localparam logic [RETRY_W-1:0]     RETRY_RESET = 3'd3;

   // segments per command
   localparam logic [SEG_W-1:0] SEG_START_TOTAL = 5'd30;
   localparam logic [SEG_W-1:0] SEG_WRITE_TOTAL = 5'd27;
   localparam logic [SEG_W-1:0] SEG_READ_TOTAL  = 5'd28;
   localparam logic [SEG_W-1:0] SEG_STOP_TOTAL  = 5'd2;

   // segment landmarks
   localparam logic [SEG_W-1:0] SEG_START_BITS = 5'd3;
   localparam logic [SEG_W-1:0] SEG_START_ACK  = 5'd27;
   localparam logic [SEG_W-1:0] SEG_START_SMP  = 5'd28;
   localparam logic [SEG_W-1:0] SEG_WRITE_ACK  = 5'd24;
   localparam logic [SEG_W-1:0] SEG_WRITE_SMP  = 5'd25;
   localparam logic [SEG_W-1:0] SEG_READ_ACK   = 5'd25;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_START = 5'b00010,
      PH_WRITE = 5'b00100,
      PH_READ  = 5'b01000,
      PH_STOP  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic scl;
      logic sda;
      logic drive;
   } pins_type;

   typedef struct packed {
      logic [DELAY_CFG_W-1:0] delay_ticks;
      logic [RETRY_W-1:0]     retry_limit;
   } cfg_type;

   typedef struct packed {
      pins_type           pins;
      logic               busy;
      logic               done;
      logic               acked;
      logic [7:0]         read_data;
      logic [RETRY_W-1:0] tries_used;
   } result_type;

   typedef struct packed {
      logic [3:0] quo;
      logic [1:0] rem;
   } div3_type;

   // x/3 for a 5-bit value: (x*11)>>5 is exact below 32
   function automatic div3_type div3(input logic [SEG_W-1:0] x);
      logic [8:0] prod;
      div3_type   r;
      prod  = 9'(x) * 9'd11;
      r.quo = prod[8:5];
      r.rem = 2'(x - 5'(r.quo) * 5'd3);
      return r;
   endfunction

   function automatic pins_type mk_pins(input logic scl, input logic sda, input logic drv);
      pins_type p;
      p.scl   = scl;
      p.sda   = drv & sda;
      p.drive = drv;
      return p;
   endfunction

   function automatic pins_type bit_pins(input logic [1:0] sub, input logic b);
      return mk_pins(sub == 2'd1, b, 1'b1);
   endfunction

   function automatic pins_type ack_pins(input logic [1:0] sub);
      pins_type p;
      if (sub == 2'd2) begin
         p = mk_pins(1'b0, 1'b0, 1'b1);
      end else begin
         p = mk_pins(sub == 2'd1, 1'b0, 1'b0);
      end
      return p;
   endfunction

   function automatic logic [SEG_W-1:0] seg_total(input phase_type ph);
      logic [SEG_W-1:0] t;
      unique case (ph)
         PH_START: t = SEG_START_TOTAL;
         PH_WRITE: t = SEG_WRITE_TOTAL;
         PH_READ:  t = SEG_READ_TOTAL;
         default:  t = SEG_STOP_TOTAL;
      endcase
      return t;
   endfunction

endpackage

/* src/i2c_bit_level_master_top.sv */
// A word accepted on req appears on rsp in the cycle after it is accepted.
// Throughput: one word per cycle; req_ready drops only while a result is
// held in the output register and rsp_ready is low.
// Reset (synchronous, active high): sequencer idle, pins SCL high with SDA
// driven high, delay_ticks 10, retry_limit 3, output register empty.
module i2c_bit_level_master_top #(
   parameter int DELAY_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [6:0]  req_address,
   input  logic        req_read_not_write,
   input  logic [7:0]  req_write_data,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_out,
   output logic        rsp_sda_out,
   output logic        rsp_sda_drive,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic        rsp_acked,
   output logic [7:0]  rsp_read_data,
   output logic [2:0]  rsp_tries_used,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   i2cm_pkg::cfg_type    cfg;
   i2cm_pkg::result_type seq_result, rsp_word;
   logic                 req_fire;

   assign req_fire = req_valid && req_ready;

   i2cm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   i2cm_seq #(
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .step           (req_fire),
      .cfg            (cfg),
      .command        (req_command),
      .address        (req_address),
      .read_not_write (req_read_not_write),
      .write_data     (req_write_data),
      .sda_in         (req_sda_in),
      .result         (seq_result)
   );

   i2cm_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (req_fire),
      .in_data   (seq_result),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_word)
   );

   assign rsp_scl_out    = rsp_word.pins.scl;
   assign rsp_sda_out    = rsp_word.pins.sda;
   assign rsp_sda_drive  = rsp_word.pins.drive;
   assign rsp_busy_res   = rsp_word.busy;
   assign rsp_done_res   = rsp_word.done;
   assign rsp_acked      = rsp_word.acked;
   assign rsp_read_data  = rsp_word.read_data;
   assign rsp_tries_used = rsp_word.tries_used;

endmodule

/* src/i2cm_csr.sv */
module i2cm_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_en,
   input  logic                        csr_index,
   input  logic [i2cm_pkg::DELAY_CFG_W-1:0] csr_wdata,
   output i2cm_pkg::cfg_type           cfg
);

   i2cm_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            i2cm_pkg::CSR_DELAY: cfg_in.delay_ticks = csr_wdata;
            i2cm_pkg::CSR_RETRY: cfg_in.retry_limit = csr_wdata[i2cm_pkg::RETRY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_ticks <= i2cm_pkg::DELAY_RESET;
         cfg_ff.retry_limit <= i2cm_pkg::RETRY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* src/i2cm_seq.sv */
module i2cm_seq #(
   parameter int DELAY_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  i2cm_pkg::cfg_type      cfg,
   input  logic [2:0]             command,
   input  logic [6:0]             address,
   input  logic                   read_not_write,
   input  logic [7:0]             write_data,
   input  logic                   sda_in,
   output i2cm_pkg::result_type   result
);

   localparam int SW = i2cm_pkg::SEG_W;
   localparam int RW = i2cm_pkg::RETRY_W;

   i2cm_pkg::phase_type ph_ff, ph_in, ph_e;
   logic [SW-1:0]          seg_ff, seg_in, seg_e, seg_p1;
   logic [7:0]             sh_ff, sh_in, sh_e;
   logic [DELAY_WIDTH-1:0] dc_ff, dc_in, dc_e;
   logic [RW-1:0]          try_ff, try_in, try_e;
   logic                   ack_ff, ack_in;
   logic [7:0]             rdb_ff, rdb_in;
   i2cm_pkg::pins_type     pins_ff, pins_in, seg_pins;

   logic [31:0]            dt_ext;
   logic [DELAY_WIDTH-1:0] eff_raw, eff;
   logic [RW-1:0]          lim;
   logic                   last_tick, busy, done;
   i2cm_pkg::div3_type     d_s, d_s1, d_s3;

   assign dt_ext  = 32'(cfg.delay_ticks);
   assign eff_raw = dt_ext[DELAY_WIDTH-1:0];
   assign eff     = (eff_raw == '0) ? {{(DELAY_WIDTH-1){1'b0}}, 1'b1} : eff_raw;
   assign lim     = (cfg.retry_limit == '0) ? RW'(1) : cfg.retry_limit;

   // command load, seen in the same tick
   always_comb begin
      ph_e  = ph_ff;
      seg_e = seg_ff;
      dc_e  = dc_ff;
      sh_e  = sh_ff;
      try_e = try_ff;
      if (ph_ff == i2cm_pkg::PH_IDLE) begin
         case (command)
            i2cm_pkg::CMD_START: begin
               ph_e  = i2cm_pkg::PH_START;
               seg_e = '0;
               dc_e  = '0;
               sh_e  = {address, read_not_write};
               try_e = RW'(1);
            end
            i2cm_pkg::CMD_WRITE: begin
               ph_e  = i2cm_pkg::PH_WRITE;
               seg_e = '0;
               dc_e  = '0;
               sh_e  = write_data;
               try_e = RW'(1);
            end
            i2cm_pkg::CMD_READ: begin
               ph_e  = i2cm_pkg::PH_READ;
               seg_e = '0;
               dc_e  = '0;
               sh_e  = '0;
            end
            i2cm_pkg::CMD_STOP: begin
               ph_e  = i2cm_pkg::PH_STOP;
               seg_e = '0;
               dc_e  = '0;
            end
            default: ;
         endcase
      end
   end

   assign d_s  = i2cm_pkg::div3(seg_e);
   assign d_s1 = i2cm_pkg::div3(seg_e - SW'(1));
   assign d_s3 = i2cm_pkg::div3(seg_e - i2cm_pkg::SEG_START_BITS);

   // pin levels of the current segment
   always_comb begin
      unique case (ph_e)
         i2cm_pkg::PH_START: begin
            if (seg_e == SW'(0)) begin
               seg_pins = i2cm_pkg::mk_pins(1'b1, 1'b1, 1'b1);
            end else if (seg_e == SW'(1)) begin
               seg_pins = i2cm_pkg::mk_pins(1'b1, 1'b0, 1'b1);
            end else if (seg_e == SW'(2)) begin
               seg_pins = i2cm_pkg::mk_pins(1'b0, 1'b0, 1'b1);
            end else if (seg_e < i2cm_pkg::SEG_START_ACK) begin
               seg_pins = i2cm_pkg::bit_pins(d_s3.rem, sh_e[3'd7 - d_s3.quo[2:0]]);
            end else begin
               seg_pins = i2cm_pkg::ack_pins(2'(seg_e - i2cm_pkg::SEG_START_ACK));
            end
         end
         i2cm_pkg::PH_WRITE: begin
            if (seg_e < i2cm_pkg::SEG_WRITE_ACK) begin
               seg_pins = i2cm_pkg::bit_pins(d_s.rem, sh_e[3'd7 - d_s.quo[2:0]]);
            end else begin
               seg_pins = i2cm_pkg::ack_pins(2'(seg_e - i2cm_pkg::SEG_WRITE_ACK));
            end
         end
         i2cm_pkg::PH_READ: begin
            if (seg_e == SW'(0)) begin
               seg_pins = i2cm_pkg::mk_pins(1'b0, 1'b0, 1'b0);
            end else if (seg_e < i2cm_pkg::SEG_READ_ACK) begin
               seg_pins = i2cm_pkg::mk_pins(d_s1.rem == 2'd1, 1'b0, 1'b0);
            end else begin
               seg_pins = i2cm_pkg::bit_pins(2'(seg_e - i2cm_pkg::SEG_READ_ACK), 1'b0);
            end
         end
         i2cm_pkg::PH_STOP: begin
            seg_pins = (seg_e == SW'(0)) ? i2cm_pkg::mk_pins(1'b0, 1'b0, 1'b1)
                                         : i2cm_pkg::mk_pins(1'b1, 1'b0, 1'b1);
         end
         default: seg_pins = pins_ff;
      endcase
   end

   assign last_tick = ({1'b0, dc_e} + (DELAY_WIDTH+1)'(1)) >= {1'b0, eff};
   assign seg_p1    = seg_e + SW'(1);

   always_comb begin
      ph_in   = ph_e;
      seg_in  = seg_e;
      dc_in   = dc_e;
      sh_in   = sh_e;
      try_in  = try_e;
      ack_in  = ack_ff;
      rdb_in  = rdb_ff;
      pins_in = pins_ff;
      busy    = 1'b0;
      done    = 1'b0;
      if (ph_e != i2cm_pkg::PH_IDLE) begin
         busy    = 1'b1;
         pins_in = seg_pins;
         // read bit: first tick of each scl-high segment
         if (ph_e == i2cm_pkg::PH_READ && seg_e >= SW'(1) &&
             seg_e < i2cm_pkg::SEG_READ_ACK && d_s1.rem == 2'd1 && dc_e == '0 && sda_in) begin
            sh_in[3'd7 - d_s1.quo[2:0]] = 1'b1;
         end
         // ack: last tick of the scl-high ack segment
         if (last_tick &&
             ((ph_e == i2cm_pkg::PH_START && seg_e == i2cm_pkg::SEG_START_SMP) ||
              (ph_e == i2cm_pkg::PH_WRITE && seg_e == i2cm_pkg::SEG_WRITE_SMP))) begin
            ack_in = ~sda_in;
         end
         if (last_tick) begin
            dc_in = '0;
            if (seg_p1 >= i2cm_pkg::seg_total(ph_e)) begin
               seg_in = '0;
               if ((ph_e == i2cm_pkg::PH_START || ph_e == i2cm_pkg::PH_WRITE) &&
                   !ack_in && try_e < lim) begin
                  try_in = try_e + RW'(1);
               end else begin
                  done = 1'b1;
                  if (ph_e == i2cm_pkg::PH_READ) begin
                     rdb_in = sh_in;
                  end
                  if (ph_e == i2cm_pkg::PH_STOP) begin
                     pins_in = i2cm_pkg::mk_pins(1'b1, 1'b1, 1'b1);
                  end
                  ph_in = i2cm_pkg::PH_IDLE;
               end
            end else begin
               seg_in = seg_p1;
            end
         end else begin
            dc_in = dc_e + DELAY_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= i2cm_pkg::PH_IDLE;
         seg_ff  <= '0;
         dc_ff   <= '0;
         sh_ff   <= '0;
         try_ff  <= '0;
         ack_ff  <= 1'b0;
         rdb_ff  <= '0;
         pins_ff <= i2cm_pkg::mk_pins(1'b1, 1'b1, 1'b1);
      end else if (step) begin
         ph_ff   <= ph_in;
         seg_ff  <= seg_in;
         dc_ff   <= dc_in;
         sh_ff   <= sh_in;
         try_ff  <= try_in;
         ack_ff  <= ack_in;
         rdb_ff  <= rdb_in;
         pins_ff <= pins_in;
      end
   end

   always_comb begin
      result.pins       = pins_in;
      result.busy       = busy;
      result.done       = done;
      result.acked      = ack_in;
      result.read_data  = rdb_in;
      result.tries_used = try_in;
   end

endmodule

/* src/i2cm_out_reg.sv */
module i2cm_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_fire,
   input  i2cm_pkg::result_type in_data,
   output logic                 in_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output i2cm_pkg::result_type out_data
);

   logic                 valid_ff, valid_in;
   i2cm_pkg::result_type data_ff;

   // a held word can leave in the same cycle a new one lands
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_fire || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* src/i2cm_checker.sv */
module i2cm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_sda_out,
   input logic       rsp_sda_drive,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [7:0] rsp_read_data
);

   // an accepted tick always yields a word next cycle
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted word produced no response");

   // input side never stalls while the output side can drain
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("req_ready low while output register free");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_busy_res)
      else $error("done without busy");

   // released SDA reads as low
   a_released_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sda_drive |-> !rsp_sda_out)
      else $error("sda_out high while released");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("stalled response changed");

endmodule

bind i2c_bit_level_master_top i2cm_checker u_i2cm_checker (.*);
